@@ hdl/length_prefixed_object_validator_defines.svh @@
// Assertion macros for the record validator RTL.
`ifndef LENGTH_PREFIXED_OBJECT_VALIDATOR_DEFINES_SVH
`define LENGTH_PREFIXED_OBJECT_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LPOV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LPOV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lpov_pkg.sv @@
// Types and constants for the length-prefixed object record validator.
`default_nettype none

package lpov_pkg;

    // Field tags, also used as parse phases
    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_VERSION = 4'd1;
    localparam logic [3:0] PH_CLEN    = 4'd2;
    localparam logic [3:0] PH_CLOCK   = 4'd3;
    localparam logic [3:0] PH_SCOUNT  = 4'd4;
    localparam logic [3:0] PH_VLEN    = 4'd5;
    localparam logic [3:0] PH_VALUE   = 4'd6;
    localparam logic [3:0] PH_MLEN    = 4'd7;
    localparam logic [3:0] PH_META    = 4'd8;
    localparam logic [3:0] PH_IGNORE  = 4'd9;

    // Record status codes
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_GOOD    = 3'd1;
    localparam logic [2:0] ST_SHORT   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_FIT     = 3'd4;

    localparam logic [7:0]  MAGIC_BYTE   = 8'h35;
    localparam logic [7:0]  VERSION_BYTE = 8'h01;
    localparam logic [30:0] LEN_BYTES    = 31'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  field_tag;
        logic [30:0] field_offset;
        logic [30:0] sibling_index;
        logic        record_done;
        logic [2:0]  record_status;
    } t_out_word;

endpackage

`default_nettype wire

@@ hdl/lpov_parse.sv @@
// Record parse state and the per-word tagging and verdict logic.
`default_nettype none
`include "length_prefixed_object_validator_defines.svh"

module lpov_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire lpov_pkg::t_in_word i_word,
    output lpov_pkg::t_out_word     o_result
);
    import lpov_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [30:0] r_count, n_count;
    logic [31:0] r_len, n_len;
    logic [30:0] r_left, n_left;
    logic [30:0] r_seen, n_seen;
    logic [2:0]  r_err, n_err;

    logic [3:0]  tag;
    logic [30:0] cnt_inc;
    logic [31:0] shifted;
    logic        fin;
    logic [3:0]  fin_ph;
    logic [30:0] left_dec;
    logic [2:0]  status;

    always_comb begin
        tag      = (r_phase <= PH_IGNORE) ? r_phase : PH_IGNORE;
        cnt_inc  = r_count + 31'd1;
        shifted  = {r_len[23:0], i_word.data_byte};
        left_dec = r_left - 31'd1;

        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        n_left  = r_left;
        n_seen  = r_seen;
        n_err   = r_err;
        fin     = 1'b0;
        fin_ph  = PH_META;

        case (tag)
            PH_MAGIC: begin
                n_count = '0;
                n_len   = '0;
                if (i_word.data_byte != MAGIC_BYTE) begin
                    n_err   = ST_SHORT;
                    n_phase = PH_IGNORE;
                end else begin
                    n_phase = PH_VERSION;
                end
            end
            PH_VERSION: begin
                n_count = '0;
                n_len   = '0;
                if (i_word.data_byte != VERSION_BYTE) begin
                    n_err   = ST_VERSION;
                    n_phase = PH_IGNORE;
                end else begin
                    n_phase = PH_CLEN;
                end
            end
            PH_CLEN, PH_SCOUNT, PH_VLEN, PH_MLEN: begin
                n_len   = shifted;
                n_count = cnt_inc;
                if (cnt_inc >= LEN_BYTES) begin
                    n_count = '0;
                    if (tag == PH_SCOUNT) begin
                        n_len = '0;
                        if (shifted[31] || shifted == '0) begin
                            n_phase = PH_IGNORE;
                        end else begin
                            n_left  = shifted[30:0];
                            n_seen  = '0;
                            n_phase = PH_VLEN;
                        end
                    end else if (shifted[31]) begin
                        n_err   = ST_FIT;
                        n_len   = '0;
                        n_phase = PH_IGNORE;
                    end else if (shifted == '0) begin
                        // empty data field: skip straight past it
                        fin    = 1'b1;
                        fin_ph = 4'(tag + 4'd1);
                    end else begin
                        n_phase = 4'(tag + 4'd1);
                    end
                end
            end
            PH_CLOCK, PH_VALUE, PH_META: begin
                n_count = cnt_inc;
                if ({1'b0, cnt_inc} >= r_len) begin
                    fin    = 1'b1;
                    fin_ph = tag;
                end
            end
            default: begin
                n_phase = PH_IGNORE;
            end
        endcase

        if (fin) begin
            n_count = '0;
            n_len   = '0;
            case (fin_ph)
                PH_CLOCK: n_phase = PH_SCOUNT;
                PH_VALUE: n_phase = PH_MLEN;
                default: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = PH_IGNORE;
                    end else begin
                        n_seen  = r_seen + 31'd1;
                        n_phase = PH_VLEN;
                    end
                end
            endcase
        end

        status = ST_PENDING;
        if (i_word.last_byte) begin
            if (n_err != ST_PENDING) begin
                status = n_err;
            end else if (n_phase == PH_IGNORE) begin
                status = ST_GOOD;
            end else if (n_phase == PH_VLEN && n_count == '0) begin
                status = ST_GOOD;
            end else if (n_phase == PH_MAGIC || n_phase == PH_VERSION) begin
                status = ST_SHORT;
            end else begin
                status = ST_FIT;
            end
            // start over on the next record
            n_phase = PH_MAGIC;
            n_count = '0;
            n_len   = '0;
            n_left  = '0;
            n_seen  = '0;
            n_err   = ST_PENDING;
        end

        o_result.field_tag     = tag;
        o_result.field_offset  = (tag != PH_IGNORE) ? r_count : '0;
        o_result.sibling_index = (tag inside {[PH_VLEN:PH_META]}) ? r_seen : '0;
        o_result.record_done   = i_word.last_byte;
        o_result.record_status = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_count <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_seen  <= '0;
            r_err   <= ST_PENDING;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_left  <= n_left;
            r_seen  <= n_seen;
            r_err   <= n_err;
        end
    end

    `LPOV_ASSERT_NOW(a_status_only_final, o_result.record_status != ST_PENDING, o_result.record_done, "status given on a word that does not end the record")
    `LPOV_ASSERT_NEXT(a_restart_after_last, i_step && i_word.last_byte, r_phase == PH_MAGIC && r_err == ST_PENDING && r_count == '0, "parser did not restart after the final word")
    `LPOV_ASSERT_NOW(a_length_count, r_phase == PH_CLEN || r_phase == PH_SCOUNT || r_phase == PH_VLEN || r_phase == PH_MLEN, r_count < LEN_BYTES, "length field ran past four bytes")
    `LPOV_ASSERT_NOW(a_data_count, r_phase == PH_CLOCK || r_phase == PH_VALUE || r_phase == PH_META, (32'(r_count) < r_len) && !r_len[31], "data field count outside its length")
    `LPOV_ASSERT_NOW(a_siblings_left, r_phase == PH_VLEN || r_phase == PH_VALUE || r_phase == PH_MLEN || r_phase == PH_META, r_left != '0, "sibling phase with no siblings left")

endmodule

`default_nettype wire

@@ hdl/length_prefixed_object_validator.sv @@
// Top level: stored object record validator with input and result registers.
//
//  channel  direction  handshake                 word
//  input    in         i_in_valid / o_in_stall   i_in_word  (data_byte, last_byte)
//  output   out        o_out_valid / i_out_stall o_out_word (tag, offset, sibling, done, status)
//
// One word in, one result word out; a word is accepted every cycle while unstalled.
// Each word passes the input register, then the result register after the parse step.
// The parse step is one pass of the phase/counter update between those two registers.
// Synchronous active-low reset empties both registers and returns the parser to magic.
// A stall on the output holds the result and backs up into the input register, which then stalls the input.
`default_nettype none

module length_prefixed_object_validator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lpov_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lpov_pkg::t_out_word      o_out_word
);
    import lpov_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      advance;
    logic      step;

    // result register frees up when empty or being taken
    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    lpov_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (step) begin
            r_out_word <= result;
        end
    end

endmodule

`default_nettype wire
